// File: rtl/nectx_pkg.sv
// Package for the NEC infrared frame transmitter.
// Holds the segment phase type, operation and register codes, and reset values.
// No dependencies.
`default_nettype none

package nectx_pkg;

  localparam int TICKS_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int WORD_W      = 32;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_STOP_MARK = 3'd5
  } phase_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_STOP_MARK    = 3'd5,
    REG_ADDRESS_LOW  = 3'd6,
    REG_ADDRESS_HIGH = 3'd7
  } reg_index_t;

  localparam logic [TICKS_W-1:0] RST_HEADER_MARK  = 16'd692;
  localparam logic [TICKS_W-1:0] RST_HEADER_SPACE = 16'd346;
  localparam logic [TICKS_W-1:0] RST_BIT_MARK     = 16'd43;
  localparam logic [TICKS_W-1:0] RST_ZERO_SPACE   = 16'd43;
  localparam logic [TICKS_W-1:0] RST_ONE_SPACE    = 16'd130;
  localparam logic [TICKS_W-1:0] RST_STOP_MARK    = 16'd130;
  localparam logic [BYTE_W-1:0]  RST_ADDRESS_LOW  = 8'd0;
  localparam logic [BYTE_W-1:0]  RST_ADDRESS_HIGH = 8'd1;

  function automatic logic is_mark(input phase_t ph);
    return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
  endfunction

endpackage

`default_nettype wire

// File: rtl/nectx_channels.sv
// Valid/ready channel interfaces for the NEC infrared frame transmitter.
// Depends on nectx_pkg for field widths.
`default_nettype none

interface nectx_in_if
  import nectx_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface nectx_out_if;
  logic valid;
  logic ready;
  logic ir_out;
  logic busy_res;
  logic frame_done;

  modport source (output valid, output ir_out, output busy_res, output frame_done,
                  input ready);
  modport sink   (input valid, input ir_out, input busy_res, input frame_done,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/nec_ir_frame_transmitter_top.sv
// NEC infrared frame transmitter: segment sequencer, config registers, result register.
// Depends on nectx_pkg and the channel interfaces in nectx_channels.sv.
//
// Usage:
//   in_ch carries one item per transfer: a carrier half-period tick
//   (operation = OP_TICK) or a frame start request (operation = OP_START)
//   with the command byte. Every item yields exactly one result on out_ch:
//   emitter level, busy flag, and a done flag on the tick ending the stop mark.
//   A start while a frame is in progress is ignored.
//   Timing: the sequencer state updates in the cycle of the input transfer and
//   the result sits in a single output register, valid in the following cycle.
//   One item per cycle is accepted as long as the output register is empty
//   or is being drained in the same cycle.
//   Stall: when out_ch.ready is low with a result waiting, in_ch.ready drops
//   and the sequencer holds until the result is taken.
//   Reset (rst, synchronous): sequencer idle, timing and address registers at
//   their defaults, output register empty.
//   Config: cfg_wr_en/cfg_index/cfg_wr_data write one register per cycle;
//   write only while no frame is running.
`default_nettype none

module nec_ir_frame_transmitter_top
  import nectx_pkg::*;
#(
  parameter int FRAME_BITS       = 32,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
  nectx_in_if.sink                    in_ch,
  nectx_out_if.source                 out_ch
);

  localparam int BIT_IDX_W = $clog2(FRAME_BITS);
  localparam int CMP_W     = (TICK_COUNT_WIDTH > TICKS_W) ? TICK_COUNT_WIDTH : TICKS_W;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(FRAME_BITS - 1);
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({TICK_COUNT_WIDTH{1'b1}});

  // configuration registers
  logic [TICKS_W-1:0] header_mark_ticks, header_space_ticks, bit_mark_ticks;
  logic [TICKS_W-1:0] zero_space_ticks, one_space_ticks, stop_mark_ticks;
  logic [BYTE_W-1:0]  address_low, address_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_ticks  <= RST_HEADER_MARK;
      header_space_ticks <= RST_HEADER_SPACE;
      bit_mark_ticks     <= RST_BIT_MARK;
      zero_space_ticks   <= RST_ZERO_SPACE;
      one_space_ticks    <= RST_ONE_SPACE;
      stop_mark_ticks    <= RST_STOP_MARK;
      address_low        <= RST_ADDRESS_LOW;
      address_high       <= RST_ADDRESS_HIGH;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEADER_MARK:  header_mark_ticks  <= cfg_wr_data;
        REG_HEADER_SPACE: header_space_ticks <= cfg_wr_data;
        REG_BIT_MARK:     bit_mark_ticks     <= cfg_wr_data;
        REG_ZERO_SPACE:   zero_space_ticks   <= cfg_wr_data;
        REG_ONE_SPACE:    one_space_ticks    <= cfg_wr_data;
        REG_STOP_MARK:    stop_mark_ticks    <= cfg_wr_data;
        REG_ADDRESS_LOW:  address_low        <= cfg_wr_data[BYTE_W-1:0];
        REG_ADDRESS_HIGH: address_high       <= cfg_wr_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_t                      phase, phase_next;
  logic [BIT_IDX_W-1:0]        bit_index, bit_index_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [FRAME_BITS-1:0]       frame_shift, frame_shift_next;
  logic                        carrier_level, carrier_level_next;
  logic                        done;

  // result register
  logic out_valid, ir_out_q, busy_q, done_q;

  logic accept;
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  logic [WORD_W-1:0]           frame_word;
  logic [TICKS_W-1:0]          seg_len;
  logic [CMP_W-1:0]            len_sat;
  logic [TICK_COUNT_WIDTH-1:0] count_inc;
  logic                        seg_end;

  always_comb begin
    frame_word = {~in_ch.data_byte, in_ch.data_byte, address_high, address_low};

    unique case (phase)
      PH_HDR_MARK:  seg_len = header_mark_ticks;
      PH_HDR_SPACE: seg_len = header_space_ticks;
      PH_BIT_MARK:  seg_len = bit_mark_ticks;
      PH_BIT_SPACE: seg_len = frame_shift[0] ? one_space_ticks : zero_space_ticks;
      PH_STOP_MARK: seg_len = stop_mark_ticks;
      default:      seg_len = '0;
    endcase

    // saturate the length at the counter range; zero length ends on the first tick
    len_sat   = (CMP_W'(seg_len) > COUNT_MAX) ? COUNT_MAX : CMP_W'(seg_len);
    count_inc = tick_count + 1'b1;
    seg_end   = (count_inc == '0) || (CMP_W'(count_inc) >= len_sat);

    phase_next         = phase;
    bit_index_next     = bit_index;
    tick_count_next    = tick_count;
    frame_shift_next   = frame_shift;
    carrier_level_next = carrier_level;
    done               = 1'b0;

    if (op_t'(in_ch.operation) == OP_START) begin
      if (phase == PH_IDLE) begin
        frame_shift_next   = frame_word[FRAME_BITS-1:0];
        phase_next         = PH_HDR_MARK;
        bit_index_next     = '0;
        tick_count_next    = '0;
        carrier_level_next = 1'b0;
      end
    end else if (phase != PH_IDLE) begin
      carrier_level_next = is_mark(phase) ? ~carrier_level : carrier_level;
      tick_count_next    = count_inc;
      if (seg_end) begin
        tick_count_next = '0;
        if (is_mark(phase)) begin
          carrier_level_next = 1'b0;
        end
        unique case (phase)
          PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
          PH_HDR_SPACE: phase_next = PH_BIT_MARK;
          PH_BIT_MARK:  phase_next = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            frame_shift_next = frame_shift >> 1;
            if (bit_index == LAST_BIT) begin
              phase_next     = PH_STOP_MARK;
              bit_index_next = '0;
            end else begin
              phase_next     = PH_BIT_MARK;
              bit_index_next = bit_index + 1'b1;
            end
          end
          PH_STOP_MARK: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      tick_count    <= '0;
      frame_shift   <= '0;
      carrier_level <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
      frame_shift   <= frame_shift_next;
      carrier_level <= carrier_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until the transfer; load only on a new item
  always_ff @(posedge clk) begin
    if (accept) begin
      ir_out_q <= is_mark(phase_next) && carrier_level_next;
      busy_q   <= (phase_next != PH_IDLE);
      done_q   <= done;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.ir_out     = ir_out_q;
  assign out_ch.busy_res   = busy_q;
  assign out_ch.frame_done = done_q;

endmodule

`default_nettype wire

// File: bench/nec_ir_frame_transmitter_top_tb.sv
// Self-checking bench for nec_ir_frame_transmitter_top: directed frames and random traffic.
// Predicts every result item in-bench; needs nectx_pkg, nectx_channels.sv and the top module.
`default_nettype none

module nec_ir_frame_transmitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nectx_pkg::*;

  localparam int FRAME_LEN = 32;

  typedef struct packed {
    logic ir_out;
    logic busy_res;
    logic frame_done;
  } emitter_out_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] hdr_mark;
    logic [CFG_DATA_W-1:0] hdr_space;
    logic [CFG_DATA_W-1:0] bit_mark;
    logic [CFG_DATA_W-1:0] zero_space;
    logic [CFG_DATA_W-1:0] one_space;
    logic [CFG_DATA_W-1:0] stop_mark;
    logic [CFG_DATA_W-1:0] addr_low;
    logic [CFG_DATA_W-1:0] addr_high;
  } timing_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  nectx_in_if  in_ch ();
  nectx_out_if out_ch ();

  nec_ir_frame_transmitter_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Register copies and sequencer state of the predicted transmitter.
  logic [TICKS_W-1:0] len_hdr_mark   = RST_HEADER_MARK;
  logic [TICKS_W-1:0] len_hdr_space  = RST_HEADER_SPACE;
  logic [TICKS_W-1:0] len_bit_mark   = RST_BIT_MARK;
  logic [TICKS_W-1:0] len_zero_space = RST_ZERO_SPACE;
  logic [TICKS_W-1:0] len_one_space  = RST_ONE_SPACE;
  logic [TICKS_W-1:0] len_stop_mark  = RST_STOP_MARK;
  logic [BYTE_W-1:0]  addr_lo        = RST_ADDRESS_LOW;
  logic [BYTE_W-1:0]  addr_hi        = RST_ADDRESS_HIGH;

  phase_t             seq_phase    = PH_IDLE;
  logic [4:0]         bit_num      = '0;
  logic [TICKS_W-1:0] ticks_in_seg = '0;
  logic [WORD_W-1:0]  frame_word   = '0;
  logic               carrier      = 1'b0;

  emitter_out_t pending_levels[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int accepted_items = 0;
  int moved_items = 0;
  int frames_sent = 0;
  int settings_loaded = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic carrier_phase(input phase_t ph);
    return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_STOP_MARK);
  endfunction

  // Advance the predicted sequencer by one item and return the level it leaves.
  task automatic emitter_step(input op_t op, input logic [BYTE_W-1:0] cmd,
                              output emitter_out_t res);
    logic [TICKS_W-1:0] seg_len;
    logic               in_mark;
    logic               done;
    done = 1'b0;
    if (op == OP_START) begin
      if (seq_phase == PH_IDLE) begin
        frame_word   = {~cmd, cmd, addr_hi, addr_lo};
        seq_phase    = PH_HDR_MARK;
        bit_num      = '0;
        ticks_in_seg = '0;
        carrier      = 1'b0;
      end
    end else if (seq_phase != PH_IDLE) begin
      in_mark = carrier_phase(seq_phase);
      case (seq_phase)
        PH_HDR_MARK:  seg_len = len_hdr_mark;
        PH_HDR_SPACE: seg_len = len_hdr_space;
        PH_BIT_MARK:  seg_len = len_bit_mark;
        PH_BIT_SPACE: seg_len = frame_word[0] ? len_one_space : len_zero_space;
        default:      seg_len = len_stop_mark;
      endcase
      if (in_mark) carrier = ~carrier;
      ticks_in_seg = ticks_in_seg + 1'b1;
      // a zero length ends after one tick, as does a counter wrap
      if (ticks_in_seg >= seg_len || ticks_in_seg == '0) begin
        ticks_in_seg = '0;
        if (in_mark) carrier = 1'b0;
        case (seq_phase)
          PH_HDR_MARK:  seq_phase = PH_HDR_SPACE;
          PH_HDR_SPACE: seq_phase = PH_BIT_MARK;
          PH_BIT_MARK:  seq_phase = PH_BIT_SPACE;
          PH_BIT_SPACE: begin
            frame_word = frame_word >> 1;
            if (bit_num == FRAME_LEN - 1) begin
              seq_phase = PH_STOP_MARK;
              bit_num   = '0;
            end else begin
              bit_num++;
              seq_phase = PH_BIT_MARK;
            end
          end
          default: begin
            seq_phase = PH_IDLE;
            done      = 1'b1;
            frames_sent++;
          end
        endcase
      end
    end
    res.ir_out     = carrier_phase(seq_phase) & carrier;
    res.busy_res   = (seq_phase != PH_IDLE);
    res.frame_done = done;
  endtask

  task automatic report_mismatch(input string what, input logic want, input logic got);
    if (mismatches < 10)
      $display("[%0t] %s: expected %b, got %b", $time, what, want, got);
    mismatches++;
  endtask

  // Receiver: check each transfer against the oldest prediction, then pick next ready.
  initial begin
    emitter_out_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("result with nothing pending", 1'b0, 1'b1);
        end else begin
          want = pending_levels.pop_front();
          if (out_ch.ir_out !== want.ir_out)
            report_mismatch("ir_out", want.ir_out, out_ch.ir_out);
          if (out_ch.busy_res !== want.busy_res)
            report_mismatch("busy_res", want.busy_res, out_ch.busy_res);
          if (out_ch.frame_done !== want.frame_done)
            report_mismatch("frame_done", want.frame_done, out_ch.frame_done);
        end
      end
      out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Leaves valid high after the transfer; the next call or settle() changes it.
  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] cmd);
    emitter_out_t want;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    accepted_items++;
    if ((op == OP_START) == (seq_phase == PH_IDLE)) moved_items++;
    emitter_step(op, cmd, want);
    pending_levels.push_back(want);
  endtask

  // Tick out any running frame, then wait until every result has been taken.
  task automatic settle();
    while (seq_phase != PH_IDLE) send_item(OP_TICK, BYTE_W'($urandom));
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_levels.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_HEADER_MARK:  len_hdr_mark   = val;
      REG_HEADER_SPACE: len_hdr_space  = val;
      REG_BIT_MARK:     len_bit_mark   = val;
      REG_ZERO_SPACE:   len_zero_space = val;
      REG_ONE_SPACE:    len_one_space  = val;
      REG_STOP_MARK:    len_stop_mark  = val;
      REG_ADDRESS_LOW:  addr_lo        = val[BYTE_W-1:0];
      REG_ADDRESS_HIGH: addr_hi        = val[BYTE_W-1:0];
    endcase
  endtask

  task automatic load_settings(input timing_t t);
    put_reg(REG_HEADER_MARK,  t.hdr_mark);
    put_reg(REG_HEADER_SPACE, t.hdr_space);
    put_reg(REG_BIT_MARK,     t.bit_mark);
    put_reg(REG_ZERO_SPACE,   t.zero_space);
    put_reg(REG_ONE_SPACE,    t.one_space);
    put_reg(REG_STOP_MARK,    t.stop_mark);
    put_reg(REG_ADDRESS_LOW,  t.addr_low);
    put_reg(REG_ADDRESS_HIGH, t.addr_high);
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      default: return CFG_DATA_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Reset register values: idle tick, a full frame, and a start while busy.
  task automatic test_reset_defaults();
    send_item(OP_TICK, 8'hFF);
    send_item(OP_START, 8'h00);
    repeat (5) send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'hFF);
    settle();
  endtask

  // Every length at one; address bytes at opposite extremes, junk in upper data bits.
  task automatic test_minimum_segments();
    load_settings('{hdr_mark: 16'd1, hdr_space: 16'd1, bit_mark: 16'd1, zero_space: 16'd1,
                    one_space: 16'd1, stop_mark: 16'd1, addr_low: 16'hA5FF,
                    addr_high: 16'hFF00});
    send_item(OP_START, 8'hFF);
    settle();
    load_settings('{hdr_mark: 16'd1, hdr_space: 16'd1, bit_mark: 16'd1, zero_space: 16'd1,
                    one_space: 16'd1, stop_mark: 16'd1, addr_low: 16'h0000,
                    addr_high: 16'h5AFF});
    send_item(OP_START, 8'h00);
    settle();
  endtask

  // A zero length behaves as a single tick.
  task automatic test_zero_lengths();
    load_settings('{hdr_mark: 16'd0, hdr_space: 16'd0, bit_mark: 16'd0, zero_space: 16'd0,
                    one_space: 16'd0, stop_mark: 16'd0, addr_low: 16'h00A5,
                    addr_high: 16'h005A});
    send_item(OP_START, 8'h3C);
    settle();
  endtask

  // Distinct lengths so a swapped zero/one space or mark shows up; a stray start mid-frame, idle ticks after.
  task automatic test_mixed_lengths();
    load_settings('{hdr_mark: 16'd4, hdr_space: 16'd3, bit_mark: 16'd2, zero_space: 16'd3,
                    one_space: 16'd5, stop_mark: 16'd2, addr_low: 16'h0096,
                    addr_high: 16'h0069});
    send_item(OP_START, 8'h96);
    repeat (9) send_item(OP_TICK, 8'h00);
    send_item(OP_START, 8'h01);
    settle();
    repeat (3) send_item(OP_TICK, 8'hAA);
    settle();
  endtask

  // Header and stop marks past 256 ticks carry the tick counter beyond its low byte.
  task automatic test_longest_segments();
    load_settings('{hdr_mark: 16'd300, hdr_space: 16'd1, bit_mark: 16'd1, zero_space: 16'd1,
                    one_space: 16'd2, stop_mark: 16'd260, addr_low: 16'h0081,
                    addr_high: 16'h0018});
    send_item(OP_START, 8'h81);
    settle();
  endtask

  // Mostly complete frames with random content; idle ticks and busy starts as noise.
  task automatic test_random_traffic(input int rounds, input int items_per_round);
    timing_t t;
    int      goal;
    op_t     op;
    for (int r = 0; r < rounds; r++) begin
      t.hdr_mark   = pick_len();
      t.hdr_space  = pick_len();
      t.bit_mark   = pick_len();
      t.zero_space = pick_len();
      t.one_space  = pick_len();
      t.stop_mark  = pick_len();
      t.addr_low   = CFG_DATA_W'($urandom);
      t.addr_high  = CFG_DATA_W'($urandom);
      load_settings(t);
      goal = moved_items + items_per_round;
      while (moved_items < goal) begin
        if (seq_phase == PH_IDLE)
          op = ($urandom_range(99) < 85) ? OP_START : OP_TICK;
        else
          op = ($urandom_range(99) < 4) ? OP_START : OP_TICK;
        send_item(op, BYTE_W'($urandom));
      end
      settle();
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_HEADER_MARK;
    cfg_wr_data     <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_TICK;
    in_ch.data_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(11, 45);
    test_reset_defaults();
    test_minimum_segments();
    test_zero_lengths();
    test_mixed_lengths();
    test_random_traffic(2, 290);

    set_idling(45, 11);
    test_random_traffic(2, 290);

    set_idling(0, 0);
    test_longest_segments();
    test_random_traffic(2, 290);

    settle();
    repeat (10) @(posedge clk);
    $display("Covered %0d transfers (%0d advanced the sequencer), %0d frames, %0d settings.",
             accepted_items, moved_items, frames_sent, settings_loaded);
    $display("Mismatching fields or stray results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/nectx_pkg.sv
rtl/nectx_channels.sv
rtl/nec_ir_frame_transmitter_top.sv
bench/nec_ir_frame_transmitter_top_tb.sv
